// ===== src/mdc_pkg.sv =====
`default_nettype none
package mdc_pkg;

	localparam int MAX_ORDER    = 4;
	localparam int ELEMENT_BITS = 16;
	localparam int IDX_BITS     = 2;
	localparam int ORDER_BITS   = 3;
	localparam int ADDR_BITS    = 2 * IDX_BITS;
	localparam int DEPTH        = MAX_ORDER * MAX_ORDER;
	localparam int FRAC_BITS    = 8;
	localparam int TARGET_FRAC  = 32;
	localparam int DET_BITS     = 64;
	localparam int PROD_BITS    = ELEMENT_BITS * MAX_ORDER;
	localparam int NUM_PERMS    = 24;
	localparam int PERM_BITS    = 5;
	localparam int ACC_BITS     = PROD_BITS + PERM_BITS;
	localparam int SCALE_BITS   = ACC_BITS + TARGET_FRAC - 2 * FRAC_BITS;

	// Permutations of four columns in lexicographic order, row 0 in the low bits.
	localparam logic [MAX_ORDER*IDX_BITS-1:0] PERM_COLS [NUM_PERMS] = '{
		{2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0},
		{2'd3, 2'd1, 2'd2, 2'd0}, {2'd1, 2'd3, 2'd2, 2'd0},
		{2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
		{2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1},
		{2'd3, 2'd0, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd2, 2'd1},
		{2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
		{2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2},
		{2'd3, 2'd0, 2'd1, 2'd2}, {2'd0, 2'd3, 2'd1, 2'd2},
		{2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
		{2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3},
		{2'd2, 2'd0, 2'd1, 2'd3}, {2'd0, 2'd2, 2'd1, 2'd3},
		{2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
	};

	// Odd permutations get a negative cofactor sign.
	localparam logic [NUM_PERMS-1:0] PERM_ODD = 24'h666666;

	typedef struct packed {
		logic                  clear_acc;
		logic                  mul_en;
		logic                  mul_first;
		logic [IDX_BITS-1:0]   rd_row;
		logic [IDX_BITS-1:0]   rd_col;
		logic                  acc_en;
		logic                  acc_neg;
		logic                  finish;
		logic [ORDER_BITS-1:0] order_n;
	} mdc_cmd_t;

	typedef struct packed {
		logic out_free;
	} mdc_stat_t;

	function automatic logic [IDX_BITS-1:0] perm_col(input logic [PERM_BITS-1:0] idx,
							 input logic [IDX_BITS-1:0] row);
		logic [MAX_ORDER*IDX_BITS-1:0] cols;
		cols = PERM_COLS[idx];
		return cols[row*IDX_BITS +: IDX_BITS];
	endfunction

	// A term belongs to the leading n x n minor when every row at or past n
	// keeps its own column.
	function automatic logic perm_fits(input logic [PERM_BITS-1:0] idx,
					   input logic [ORDER_BITS-1:0] n);
		logic [MAX_ORDER*IDX_BITS-1:0] cols;
		logic ok;
		cols = PERM_COLS[idx];
		ok = 1'b1;
		for (int r = 0; r < MAX_ORDER; r++) begin
			if (ORDER_BITS'(r) >= n && cols[r*IDX_BITS +: IDX_BITS] != IDX_BITS'(r))
				ok = 1'b0;
		end
		return ok;
	endfunction

endpackage
`default_nettype wire

// ===== src/mdc_if.sv =====
`default_nettype none
interface mdc_load_if import mdc_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic        [IDX_BITS-1:0]     row_index;
	logic        [IDX_BITS-1:0]     col_index;
	logic signed [ELEMENT_BITS-1:0] element;
	logic                           compute;

	modport source(output valid, row_index, col_index, element, compute, input ready);
	modport sink(input valid, row_index, col_index, element, compute, output ready);
endinterface

interface mdc_result_if import mdc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [DET_BITS-1:0] det_value;
	logic                       overflow;

	modport source(output valid, det_value, overflow, input ready);
	modport sink(input valid, det_value, overflow, output ready);
endinterface

interface mdc_cfg_if import mdc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ORDER_BITS-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// ===== src/mdc_ctrl.sv =====
`default_nettype none
module mdc_ctrl import mdc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load_accept,
	input  wire logic                  load_compute,
	input  wire logic                  cfg_wr,
	input  wire logic [ORDER_BITS-1:0] cfg_data,
	input  wire mdc_stat_t             stat,
	output logic                       load_ready,
	output mdc_cmd_t                   cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_ACC  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam logic [PERM_BITS-1:0] LAST_PERM = PERM_BITS'(NUM_PERMS - 1);

	logic [1:0]            state_q;
	logic [1:0]            state_d;
	logic [PERM_BITS-1:0]  perm_q;
	logic [PERM_BITS-1:0]  perm_d;
	logic [IDX_BITS-1:0]   row_q;
	logic [IDX_BITS-1:0]   row_d;
	logic [ORDER_BITS-1:0] order_q;
	logic [ORDER_BITS-1:0] n_eff;
	logic                  fits;
	logic                  last_row;

	always_comb begin
		priority if (order_q < ORDER_BITS'(2))
			n_eff = ORDER_BITS'(2);
		else if (order_q > ORDER_BITS'(MAX_ORDER))
			n_eff = ORDER_BITS'(MAX_ORDER);
		else
			n_eff = order_q;
	end

	assign fits     = perm_fits(perm_q, n_eff);
	assign last_row = {1'b0, row_q} == n_eff - ORDER_BITS'(1);

	assign load_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		perm_d  = perm_q;
		row_d   = row_q;
		unique case (state_q)
			S_IDLE: begin
				if (load_accept && load_compute) begin
					perm_d  = '0;
					row_d   = '0;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				if (!fits) begin
					// skip terms outside the leading minor
					if (perm_q == LAST_PERM)
						state_d = S_DONE;
					else
						perm_d = perm_q + PERM_BITS'(1);
				end else if (last_row) begin
					state_d = S_ACC;
				end else begin
					row_d = row_q + IDX_BITS'(1);
				end
			end
			S_ACC: begin
				row_d = '0;
				if (perm_q == LAST_PERM) begin
					state_d = S_DONE;
				end else begin
					perm_d  = perm_q + PERM_BITS'(1);
					state_d = S_MUL;
				end
			end
			S_DONE: begin
				if (stat.out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		// Store read is registered: address the element of the next cycle.
		cmd.rd_row    = row_d;
		cmd.rd_col    = perm_col(perm_d, row_d);
		cmd.order_n   = n_eff;
		cmd.mul_first = row_q == '0;
		cmd.acc_neg   = PERM_ODD[perm_q];
		unique case (state_q)
			S_IDLE: cmd.clear_acc = load_accept && load_compute;
			S_MUL:  cmd.mul_en    = fits;
			S_ACC:  cmd.acc_en    = 1'b1;
			S_DONE: cmd.finish    = stat.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_BITS'(MAX_ORDER);
		end else if (cfg_wr) begin
			order_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			perm_q  <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			perm_q  <= perm_d;
			row_q   <= row_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/mdc_datapath.sv =====
`default_nettype none
module mdc_datapath import mdc_pkg::*; (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic        [IDX_BITS-1:0]     wr_row,
	input  wire logic        [IDX_BITS-1:0]     wr_col,
	input  wire logic signed [ELEMENT_BITS-1:0] wr_data,
	input  wire mdc_cmd_t                       cmd,
	output mdc_stat_t                           stat,
	mdc_result_if.source                        result
);

	logic signed [ELEMENT_BITS-1:0]           mem_q [DEPTH];
	logic        [ADDR_BITS-1:0]              wr_addr;
	logic        [ADDR_BITS-1:0]              rd_addr;
	logic signed [ELEMENT_BITS-1:0]           factor_q;
	logic signed [PROD_BITS+ELEMENT_BITS-1:0] prod_full;
	logic signed [PROD_BITS-1:0]              prod_q;
	logic signed [ACC_BITS-1:0]               acc_q;
	logic signed [ACC_BITS-1:0]               term;
	logic signed [SCALE_BITS-1:0]             acc_ext;
	logic signed [SCALE_BITS-1:0]             scaled;
	logic                                     fits;
	logic                                     valid_q;
	logic signed [DET_BITS-1:0]               det_q;
	logic                                     ovf_q;

	assign wr_addr = {wr_row, wr_col};
	assign rd_addr = {cmd.rd_row, cmd.rd_col};

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		// Forward a write at the read address so a compute sees its own element.
		if (wr_en && wr_addr == rd_addr)
			factor_q <= wr_data;
		else
			factor_q <= mem_q[rd_addr];
	end

	assign prod_full = prod_q * factor_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			if (cmd.mul_first)
				prod_q <= PROD_BITS'(factor_q);
			else
				prod_q <= prod_full[PROD_BITS-1:0];
		end
	end

	assign term = ACC_BITS'(prod_q);

	always_ff @(posedge clk) begin
		if (cmd.clear_acc)
			acc_q <= '0;
		else if (cmd.acc_en)
			acc_q <= cmd.acc_neg ? acc_q - term : acc_q + term;
	end

	// Bring 8*n fraction bits up to Q32.32.
	assign acc_ext = SCALE_BITS'(acc_q);

	always_comb begin
		unique case (cmd.order_n)
			ORDER_BITS'(2): scaled = acc_ext <<< (TARGET_FRAC - 2 * FRAC_BITS);
			ORDER_BITS'(3): scaled = acc_ext <<< (TARGET_FRAC - 3 * FRAC_BITS);
			default:        scaled = acc_ext;
		endcase
	end

	assign fits = (&scaled[SCALE_BITS-1:DET_BITS-1]) || !(|scaled[SCALE_BITS-1:DET_BITS-1]);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (fits) begin
				det_q <= scaled[DET_BITS-1:0];
				ovf_q <= 1'b0;
			end else begin
				det_q <= scaled[SCALE_BITS-1] ? {1'b1, {(DET_BITS-1){1'b0}}}
							      : {1'b0, {(DET_BITS-1){1'b1}}};
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.finish) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign stat.out_free    = !valid_q || result.ready;
	assign result.valid     = valid_q;
	assign result.det_value = det_q;
	assign result.overflow  = ovf_q;

endmodule
`default_nettype wire

// ===== src/matrix_determinant_cofactor_core.sv =====
// Load transactions: one element per cycle while idle, stored at the accepting edge.
// Compute transaction: all 24 column orderings are walked; one in the minor is multiplied row
// by row, then accumulated, one outside it is skipped, and a final step writes the result.
// A new transaction is taken once the result sits in the output register; a held result stalls.
// Reset (arst_n low, asynchronous): order returns to 4, control and result valid clear;
// the element store is not cleared and holds junk until written.
`default_nettype none
module matrix_determinant_cofactor_core import mdc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mdc_load_if.sink     load,
	mdc_result_if.source result,
	mdc_cfg_if.sink      cfg
);

	mdc_cmd_t  cmd;
	mdc_stat_t stat;
	logic      load_accept;

	// Configuration is always taken; the host writes order only while idle.
	assign cfg.ready   = 1'b1;
	assign load_accept = load.valid && load.ready;

	// Sequencer: walks the column orderings and rows of the expansion,
	// skipping orderings that leave the leading minor.
	mdc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_accept  (load_accept),
		.load_compute (load.compute),
		.cfg_wr       (cfg.valid),
		.cfg_data     (cfg.data),
		.stat         (stat),
		.load_ready   (load.ready),
		.cmd          (cmd)
	);

	// Datapath: element store, running product, signed accumulator,
	// rescale and saturate into the output register.
	mdc_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_accept),
		.wr_row  (load.row_index),
		.wr_col  (load.col_index),
		.wr_data (load.element),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

endmodule
`default_nettype wire
